@@ hw/rtl/blrs_pkg.sv @@
package blrs_pkg;

   localparam int LEN_W   = 32;
   localparam int STAMP_W = 40;
   localparam int EVC_W   = 11;

   typedef enum logic [1:0] {
      OP_PIN    = 2'd0,
      OP_INSERT = 2'd1,
      OP_SERVE  = 2'd2,
      OP_REPORT = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STS_OK     = 2'd0,
      STS_REJECT = 2'd1,
      STS_HIT    = 2'd2,
      STS_MISS   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_EVAL,
      S_CHECK,
      S_SCAN,
      S_PICK,
      S_PLACE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [9:0]       entry;
      logic [LEN_W-1:0] offset;
      logic [LEN_W-1:0] byte_count;
      logic [LEN_W-1:0] file_length;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [EVC_W-1:0] evicted_count;
      logic [LEN_W-1:0] occupied_bytes;
   } rsp_type;

   // one stored entry of the resident map
   typedef struct packed {
      logic               held;
      logic               pinned;
      logic [LEN_W-1:0]   length;
      logic [STAMP_W-1:0] stamp;
   } ent_type;

   localparam int ENT_W = $bits(ent_type);

   typedef struct packed {
      logic clear;
      logic sample;
   } vict_ctl_type;

   typedef struct packed {
      logic               found;
      logic               pinned;
      logic [LEN_W-1:0]   length;
      logic [STAMP_W-1:0] stamp;
   } vict_pick_type;

endpackage

@@ hw/rtl/budgeted_lru_resident_set.sv @@
// Budgeted LRU resident set: tracks which file entries are held under a byte budget.
// req_ channel (valid/stall) carries one operation per beat: pin, insert, serve or
// disk read report. rsp_ channel (valid/stall) returns one beat per operation with
// status, evicted count and occupied bytes. csr_ channel (valid/ready, always ready)
// writes the byte budget; write it only while the block is idle.
// Pin, serve and rejected operations pass the lookup, evaluate and done states; no
// new one is accepted before the result is registered. For an insert or a report,
// each of its evictions is one scan of the entry RAM, one entry per cycle through
// its single read port, with one stamp comparator picking the oldest unpinned, then
// pinned file. One operation is in flight at a time; req_stall is high while it is
// worked on. A finished result sits in the output register while rsp_stall is high,
// and the next request may be accepted meanwhile; its result waits until that beat
// is taken. After reset the entry RAM is cleared one entry per cycle with req_stall
// high; the budget resets to zero, which rejects every insert.
module budgeted_lru_resident_set import blrs_pkg::*; #(
   parameter int ENTRIES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [LEN_W-1:0] csr_wdata
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               scan_vld_ff, scan_vld_in;
   logic [IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic               tgt_pinned_ff, tgt_pinned_in;
   logic [EVC_W-1:0]   evict_ff, evict_in;
   logic [LEN_W-1:0]   occ_ff, occ_in;
   logic [STAMP_W-1:0] clock_ff, clock_in;
   logic [LEN_W-1:0]   budget_ff, budget_in;
   status_type         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   ent_type            ram_wr_data;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [ENT_W-1:0]   ram_rd_bits;
   ent_type            ent;

   vict_ctl_type       vict_ctl;
   vict_pick_type      pick;
   logic [IDX_W-1:0]   pick_idx;

   logic [IDX_W-1:0]   tgt_idx;
   logic               in_range;
   logic [LEN_W-1:0]   len;
   logic [LEN_W-1:0]   add_a, add_b, cmp_ref;
   logic [LEN_W:0]     add_sum;
   logic               add_gt;
   logic               too_long;
   logic [STAMP_W-1:0] next_clock;

   blrs_ram #(
      .WIDTH (ENT_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   assign ent = ent_type'(ram_rd_bits);

   blrs_victim #(
      .IDX_W (IDX_W)
   ) u_victim (
      .clock    (clock),
      .reset    (reset),
      .ctl      (vict_ctl),
      .ent      (ent),
      .ent_idx  (scan_idx_ff),
      .pick     (pick),
      .pick_idx (pick_idx)
   );

   assign tgt_idx    = IDX_W'(req_ff.entry);
   assign in_range   = 32'(req_ff.entry) < 32'(ENTRIES);
   assign len        = req_ff.byte_count;
   assign too_long   = len > budget_ff;
   assign next_clock = clock_ff + STAMP_W'(1);

   // shared add and compare: offset + count vs length, or occupied + length vs budget
   always_comb begin
      if (state_ff == S_EVAL) begin
         add_a   = req_ff.offset;
         add_b   = req_ff.byte_count;
         cmp_ref = ent.length;
      end else begin
         add_a   = occ_ff;
         add_b   = len;
         cmp_ref = budget_ff;
      end
      add_sum = {1'b0, add_a} + {1'b0, add_b};
      add_gt  = add_sum > {1'b0, cmp_ref};
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      cnt_in        = cnt_ff;
      scan_vld_in   = 1'b0;
      scan_idx_in   = scan_idx_ff;
      tgt_pinned_in = tgt_pinned_ff;
      evict_in      = evict_ff;
      occ_in        = occ_ff;
      clock_in      = clock_ff;
      status_in     = status_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      ram_wr_en     = 1'b0;
      ram_wr_addr   = tgt_idx;
      ram_wr_data   = ent;
      ram_rd_addr   = tgt_idx;
      vict_ctl      = '0;

      case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_ff[IDX_W-1:0];
            ram_wr_data = '0;
            cnt_in      = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               evict_in = '0;
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_DONE;
            if (!in_range) begin
               status_in = (req_ff.opcode == OP_SERVE) ? STS_MISS : STS_REJECT;
            end else begin
               case (req_ff.opcode)
                  OP_PIN: begin
                     ram_wr_en          = 1'b1;
                     ram_wr_data.pinned = 1'b1;
                     status_in          = STS_OK;
                  end
                  OP_INSERT: begin
                     tgt_pinned_in = ent.pinned;
                     if (ent.held) begin
                        status_in = STS_OK;
                     end else if ((budget_ff == '0) || too_long) begin
                        status_in = STS_REJECT;
                     end else begin
                        state_in = S_CHECK;
                     end
                  end
                  OP_SERVE: begin
                     if (ent.held && !add_gt) begin
                        ram_wr_en         = 1'b1;
                        ram_wr_data.stamp = next_clock;
                        clock_in          = next_clock;
                        status_in         = STS_HIT;
                     end else begin
                        status_in = STS_MISS;
                     end
                  end
                  OP_REPORT: begin
                     tgt_pinned_in = 1'b1;
                     if (ent.pinned && !ent.held && (req_ff.offset == '0) &&
                         (req_ff.byte_count == req_ff.file_length) &&
                         (budget_ff != '0) && !too_long) begin
                        state_in = S_CHECK;
                     end else begin
                        status_in = STS_REJECT;
                     end
                  end
                  default: begin
                     status_in = STS_REJECT;
                  end
               endcase
            end
         end
         S_CHECK: begin
            if (add_gt) begin
               vict_ctl.clear = 1'b1;
               cnt_in         = '0;
               state_in       = S_SCAN;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_SCAN: begin
            // issue one read per cycle, judge the entry read in the previous cycle
            vict_ctl.sample = scan_vld_ff;
            if (cnt_ff < CNT_W'(ENTRIES)) begin
               ram_rd_addr = cnt_ff[IDX_W-1:0];
               scan_vld_in = 1'b1;
               scan_idx_in = cnt_ff[IDX_W-1:0];
               cnt_in      = cnt_ff + CNT_W'(1);
            end else if (!scan_vld_ff) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (pick.found) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = pick_idx;
               ram_wr_data = '{held: 1'b0, pinned: pick.pinned,
                               length: pick.length, stamp: pick.stamp};
               occ_in      = occ_ff - pick.length;
               evict_in    = evict_ff + EVC_W'(1);
               state_in    = S_CHECK;
            end else begin
               status_in = STS_REJECT;
               state_in  = S_DONE;
            end
         end
         S_PLACE: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = '{held: 1'b1, pinned: tgt_pinned_ff,
                            length: len, stamp: next_clock};
            clock_in    = next_clock;
            occ_in      = occ_ff + len;
            status_in   = STS_OK;
            state_in    = S_DONE;
         end
         S_DONE: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.status         = status_ff;
               rsp_in.evicted_count  = evict_ff;
               rsp_in.occupied_bytes = occ_ff;
               rsp_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign budget_in = csr_valid ? csr_wdata : budget_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         scan_vld_ff  <= 1'b0;
         evict_ff     <= '0;
         occ_ff       <= '0;
         clock_ff     <= '0;
         budget_ff    <= '0;
         status_ff    <= STS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         scan_vld_ff  <= scan_vld_in;
         evict_ff     <= evict_in;
         occ_ff       <= occ_in;
         clock_ff     <= clock_in;
         budget_ff    <= budget_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff        <= req_in;
      scan_idx_ff   <= scan_idx_in;
      tgt_pinned_ff <= tgt_pinned_in;
      rsp_ff        <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

@@ hw/rtl/blrs_ram.sv @@
module blrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/blrs_victim.sv @@
module blrs_victim import blrs_pkg::*; #(
   parameter int IDX_W = 10
) (
   input  logic          clock,
   input  logic          reset,
   input  vict_ctl_type  ctl,
   input  ent_type       ent,
   input  logic [IDX_W-1:0] ent_idx,
   output vict_pick_type pick,
   output logic [IDX_W-1:0] pick_idx
);

   logic               u_found_ff, u_found_in;
   logic               p_found_ff, p_found_in;
   logic [IDX_W-1:0]   u_idx_ff, u_idx_in, p_idx_ff, p_idx_in;
   logic [LEN_W-1:0]   u_len_ff, u_len_in, p_len_ff, p_len_in;
   logic [STAMP_W-1:0] u_stamp_ff, u_stamp_in, p_stamp_ff, p_stamp_in;

   logic               cur_found;
   logic [STAMP_W-1:0] cur_stamp;
   logic               take;

   // one stamp comparator serves both classes
   always_comb begin
      cur_found = ent.pinned ? p_found_ff : u_found_ff;
      cur_stamp = ent.pinned ? p_stamp_ff : u_stamp_ff;
      take      = ctl.sample && ent.held && (!cur_found || (ent.stamp < cur_stamp));

      u_found_in = u_found_ff;
      u_idx_in   = u_idx_ff;
      u_len_in   = u_len_ff;
      u_stamp_in = u_stamp_ff;
      p_found_in = p_found_ff;
      p_idx_in   = p_idx_ff;
      p_len_in   = p_len_ff;
      p_stamp_in = p_stamp_ff;

      if (ctl.clear) begin
         u_found_in = 1'b0;
         p_found_in = 1'b0;
      end else if (take) begin
         if (ent.pinned) begin
            p_found_in = 1'b1;
            p_idx_in   = ent_idx;
            p_len_in   = ent.length;
            p_stamp_in = ent.stamp;
         end else begin
            u_found_in = 1'b1;
            u_idx_in   = ent_idx;
            u_len_in   = ent.length;
            u_stamp_in = ent.stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u_found_ff <= 1'b0;
         p_found_ff <= 1'b0;
      end else begin
         u_found_ff <= u_found_in;
         p_found_ff <= p_found_in;
      end
      u_idx_ff   <= u_idx_in;
      u_len_ff   <= u_len_in;
      u_stamp_ff <= u_stamp_in;
      p_idx_ff   <= p_idx_in;
      p_len_ff   <= p_len_in;
      p_stamp_ff <= p_stamp_in;
   end

   // unpinned files go before pinned ones
   always_comb begin
      pick.found  = u_found_ff || p_found_ff;
      pick.pinned = !u_found_ff;
      pick.length = u_found_ff ? u_len_ff : p_len_ff;
      pick.stamp  = u_found_ff ? u_stamp_ff : p_stamp_ff;
      pick_idx    = u_found_ff ? u_idx_ff : p_idx_ff;
   end

endmodule

@@ hw/rtl/blrs_checker.sv @@
module blrs_assertions import blrs_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input req_type     req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input rsp_type     rsp_data,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [LEN_W-1:0] csr_wdata
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // one operation at a time: stall right after an accepted request
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous one in flight");

   // reads never evict
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.status == STS_HIT) || (rsp_data.status == STS_MISS))
      |-> rsp_data.evicted_count == '0)
      else $error("serve reported evictions");

   // the request channel is stalled right after reset, while the entry RAM is cleared
   assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("request channel open right after reset");

endmodule

bind budgeted_lru_resident_set blrs_assertions u_blrs_assertions (.*);

@@ tb/blrs_checker.sv @@
module blrs_checker
   import blrs_pkg::*;
#(
   parameter int ENTRIES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  rsp_type          rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [LEN_W-1:0] csr_wdata,
   output int               fail_count,
   output int               pending,
   output int               checked,
   output int               evict_total
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow copy of the resident map
   logic               held_q  [ENTRIES];
   logic               pin_q   [ENTRIES];
   logic [LEN_W-1:0]   len_q   [ENTRIES];
   logic [STAMP_W-1:0] stamp_q [ENTRIES];
   logic [STAMP_W-1:0] use_clk;
   logic [LEN_W-1:0]   occupied;
   logic [LEN_W-1:0]   budget;
   int unsigned        drop_tally;

   rsp_type awaited_outcomes[$];
   int      n_fail;
   int      n_checked;
   int      n_evict;

   assign fail_count  = n_fail;
   assign checked     = n_checked;
   assign evict_total = n_evict;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      if (n_fail < 60)
         $display("[%0t] result %0d: %s is %0h, want %0h", $time, n_checked, what, got, want);
      n_fail++;
   endtask

   // drop the oldest held file, unpinned ones first, lowest index on a tie
   function automatic bit drop_oldest();
      int  best;
      bit  found;
      for (int pass = 0; pass < 2; pass++) begin
         found = 0;
         best  = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (held_q[i] && (pin_q[i] ? 1 : 0) == pass &&
                (!found || stamp_q[i] < stamp_q[best])) begin
               best  = i;
               found = 1;
            end
         end
         if (found) begin
            held_q[best] = 0;
            occupied     = occupied - len_q[best];
            return 1;
         end
      end
      return 0;
   endfunction

   function automatic status_type admit_file(input int n, input logic [LEN_W-1:0] n_len);
      if (held_q[n])
         return STS_OK;
      if (budget == 0 || n_len > budget)
         return STS_REJECT;
      while ({1'b0, occupied} + {1'b0, n_len} > {1'b0, budget}) begin
         if (!drop_oldest())
            return STS_REJECT;
         drop_tally++;
      end
      use_clk    = use_clk + 1'b1;
      held_q[n]  = 1;
      len_q[n]   = n_len;
      stamp_q[n] = use_clk;
      occupied   = occupied + n_len;
      return STS_OK;
   endfunction

   function automatic rsp_type resident_outcome(input req_type r);
      rsp_type    res;
      status_type st;
      int         n;
      bit         ok;
      n  = int'(r.entry);
      ok = n < ENTRIES;
      drop_tally = 0;
      case (op_type'(r.opcode))
         OP_PIN: begin
            if (ok) begin
               pin_q[n] = 1;
               st = STS_OK;
            end else begin
               st = STS_REJECT;
            end
         end
         OP_INSERT: begin
            st = ok ? admit_file(n, r.byte_count) : STS_REJECT;
         end
         OP_SERVE: begin
            if (ok && held_q[n] &&
                {1'b0, r.offset} + {1'b0, r.byte_count} <= {1'b0, len_q[n]}) begin
               use_clk    = use_clk + 1'b1;
               stamp_q[n] = use_clk;
               st = STS_HIT;
            end else begin
               st = STS_MISS;
            end
         end
         default: begin
            if (ok && pin_q[n] && !held_q[n] && r.offset == 0 &&
                r.byte_count == r.file_length && budget != 0)
               st = admit_file(n, r.byte_count);
            else
               st = STS_REJECT;
         end
      endcase
      res.status         = st;
      res.evicted_count  = drop_tally[EVC_W-1:0];
      res.occupied_bytes = occupied;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            held_q[i]  = 0;
            pin_q[i]   = 0;
            len_q[i]   = '0;
            stamp_q[i] = '0;
         end
         use_clk   = '0;
         occupied  = '0;
         budget    = '0;
         n_fail    = 0;
         n_checked = 0;
         n_evict   = 0;
         awaited_outcomes.delete();
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready)
            budget = csr_wdata;
         if (rsp_valid && !rsp_stall) begin
            if (awaited_outcomes.size() == 0) begin
               report("unrequested beat", 64'(rsp_data), 64'(0));
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_data.status !== want.status)
                  report("status", 64'(rsp_data.status), 64'(want.status));
               if (rsp_data.evicted_count !== want.evicted_count)
                  report("evicted_count", 64'(rsp_data.evicted_count),
                         64'(want.evicted_count));
               if (rsp_data.occupied_bytes !== want.occupied_bytes)
                  report("occupied_bytes", 64'(rsp_data.occupied_bytes),
                         64'(want.occupied_bytes));
               n_evict += int'(want.evicted_count);
            end
            n_checked++;
         end
         if (req_valid && !req_stall)
            awaited_outcomes.push_back(resident_outcome(req_data));
         pending <= awaited_outcomes.size();
      end
   end

endmodule

@@ tb/tb_budgeted_lru_resident_set.sv @@
module tb_budgeted_lru_resident_set;
   timeunit 1ns;
   timeprecision 1ps;
   import blrs_pkg::*;

   localparam int ENTRIES        = 1024;
   localparam int LIMIT          = 8_000_000;
   localparam int PHASES         = 5;
   localparam int ITEMS_PER_PHASE = 54;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [LEN_W-1:0] csr_wdata = '0;
   logic             quiet     = 1'b0;

   int fail_count;
   int pending;
   int checked;
   int evict_total;

   int unsigned cycle_count = 0;
   int          stall_left  = 0;
   int          sent        = 0;
   int          settings    = 0;

   logic [LEN_W-1:0] cur_budget = '0;
   logic [LEN_W-1:0] hint_len [int];
   logic [9:0]       far_entries [4] = '{10'd1023, 10'd512, 10'h155, 10'h2AA};

   budgeted_lru_resident_set #(.ENTRIES(ENTRIES)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   blrs_checker #(.ENTRIES(ENTRIES)) u_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .pending     (pending),
      .checked     (checked),
      .evict_total (evict_total)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver backpressure in random bursts
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 14);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic issue_op(input req_type r);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic issue(input op_type op, input int e, input logic [LEN_W-1:0] off,
                        input logic [LEN_W-1:0] cnt, input logic [LEN_W-1:0] flen);
      req_type r;
      r.opcode      = op;
      r.entry       = 10'(e);
      r.offset      = off;
      r.byte_count  = cnt;
      r.file_length = flen;
      issue_op(r);
   endtask

   // hold off until every result is back, then let the block go idle
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_budget(input logic [LEN_W-1:0] v);
      settle();
      csr_wdata <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      cur_budget = v;
      settings++;
   endtask

   function automatic logic [LEN_W-1:0] pick_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 70) return $urandom_range(0, cur_budget / 3);
      if (k < 80) return cur_budget;
      if (k < 88) return cur_budget + 1'b1;
      return $urandom();
   endfunction

   function automatic logic [9:0] pick_entry();
      int k;
      k = $urandom_range(0, 99);
      if (k < 85) return 10'($urandom_range(0, 11));
      if (k < 95) return far_entries[$urandom_range(0, 3)];
      return 10'($urandom_range(0, 1023));
   endfunction

   function automatic req_type random_op();
      req_type          r;
      int               k;
      int               j;
      logic [LEN_W-1:0] span;
      k = $urandom_range(0, 99);
      j = $urandom_range(0, 9);
      r.entry       = pick_entry();
      r.offset      = $urandom();
      r.byte_count  = $urandom();
      r.file_length = $urandom();
      span = hint_len.exists(int'(r.entry)) ? hint_len[int'(r.entry)] : cur_budget / 4;
      if (k < 15) begin
         r.opcode = OP_PIN;
      end else if (k < 45) begin
         r.opcode     = OP_INSERT;
         r.byte_count = pick_len();
         hint_len[int'(r.entry)] = r.byte_count;
      end else if (k < 80) begin
         r.opcode = OP_SERVE;
         if (j < 6) begin
            r.offset     = $urandom_range(0, span);
            r.byte_count = $urandom_range(0, span - r.offset);
         end else if (j < 8) begin
            // one byte past the end
            r.offset     = $urandom_range(0, span);
            r.byte_count = span - r.offset + 1'b1;
         end
      end else begin
         r.opcode = OP_REPORT;
         if (j < 7) begin
            r.offset      = '0;
            r.byte_count  = pick_len();
            r.file_length = r.byte_count;
            hint_len[int'(r.entry)] = r.byte_count;
         end else begin
            r.offset      = $urandom_range(0, 1) ? '0 : $urandom();
            r.byte_count  = pick_len();
            r.file_length = $urandom_range(0, 1) ? r.byte_count
                                                 : r.byte_count ^ 32'($urandom_range(1, 255));
         end
      end
      return r;
   endfunction

   initial begin
      logic [LEN_W-1:0] phase_budget [PHASES];
      int               directed;
      phase_budget[0] = 32'd4096;
      phase_budget[1] = $urandom() | 32'd1;
      phase_budget[2] = 32'hFFFF_FFFF;
      phase_budget[3] = 32'd1;
      phase_budget[4] = 32'd2000;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // zero budget after reset: nothing can be held
      issue(OP_INSERT, 0, 0, 100, 0);
      issue(OP_REPORT, 0, 0, 100, 100);
      issue(OP_PIN,    0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(OP_REPORT, 0, 0, 100, 100);
      issue(OP_SERVE,  0, 0, 0, 0);

      // largest budget and largest file, reads at the edge of the file
      write_budget(32'hFFFF_FFFF);
      issue(OP_INSERT, 1023, 0, 32'hFFFF_FFFF, 0);
      issue(OP_SERVE,  1023, 0, 32'hFFFF_FFFF, 0);
      issue(OP_SERVE,  1023, 32'hFFFF_FFFF, 1, 0);
      issue(OP_SERVE,  1023, 32'hFFFF_FFFF, 0, 0);
      issue(OP_INSERT, 1023, 0, 5, 0);
      issue(OP_INSERT, 2, 0, 0, 0);
      issue(OP_INSERT, 3, 0, 1, 0);

      // adoption by report, well-formed and broken
      write_budget(32'd300);
      issue(OP_PIN,    4, 0, 0, 0);
      issue(OP_REPORT, 4, 0, 200, 200);
      issue(OP_REPORT, 4, 0, 200, 200);
      issue(OP_REPORT, 5, 0, 90, 90);
      issue(OP_PIN,    5, 0, 0, 0);
      issue(OP_REPORT, 5, 4, 50, 50);
      issue(OP_REPORT, 5, 0, 50, 60);
      issue(OP_REPORT, 5, 0, 90, 90);
      issue(OP_INSERT, 6, 0, 301, 0);
      issue(OP_INSERT, 6, 0, 100, 0);

      // budget lowered below what is held
      write_budget(32'd50);
      issue(OP_INSERT, 8, 0, 10, 0);
      issue(OP_SERVE,  8, 0, 10, 0);
      issue(OP_SERVE,  8, 0, 11, 0);
      directed = sent;

      for (int p = 0; p < PHASES; p++) begin
         write_budget(phase_budget[p]);
         if (p == PHASES - 1)
            quiet <= 1'b1;
         for (int i = 0; i < ITEMS_PER_PHASE; i++)
            issue_op(random_op());
      end
      settle();

      $display("Summary: %0d requests (%0d directed) under %0d budget settings",
               sent, directed, settings);
      $display("Summary: %0d results compared, %0d evictions predicted", checked, evict_total);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ budgeted_lru_resident_set.f @@
hw/rtl/blrs_pkg.sv
hw/rtl/blrs_ram.sv
hw/rtl/blrs_victim.sv
hw/rtl/budgeted_lru_resident_set.sv
hw/rtl/blrs_checker.sv
tb/blrs_checker.sv
tb/tb_budgeted_lru_resident_set.sv
